>>> sv/imufp_pkg.sv
// Package for the IMU serial frame parser: frame constants, state and event codes,
// and the result record passed from the parser to the output register.
// Depends on nothing; the core, the parser and the result register import it.
`default_nettype none

package imufp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_LO    = 8'h50;
    localparam logic [7:0] TYPE_HI    = 8'h59;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Eight payload bytes per frame, indexed 0..7.
    localparam int unsigned PAY_BYTES = 8;
    localparam int unsigned PAY_IDX_W = $clog2(PAY_BYTES);
    localparam logic [PAY_IDX_W-1:0] PAY_LAST = PAY_IDX_W'(PAY_BYTES - 1);

    localparam int unsigned COUNT_OUT_W = 32;

    typedef enum logic [3:0] {
        ST_HUNT    = 4'b0001,
        ST_TYPE    = 4'b0010,
        ST_PAYLOAD = 4'b0100,
        ST_CHECK   = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        EV_ACCEL  = 3'd0,
        EV_GYRO   = 3'd1,
        EV_ANGLE  = 3'd2,
        EV_OTHER  = 3'd3,
        EV_BADSUM = 3'd4,
        EV_RESYNC = 3'd5
    } t_event;

    typedef struct packed {
        t_event                   event_res;
        logic [7:0]               frame_type;
        logic signed [15:0]       first_value;
        logic signed [15:0]       second_value;
        logic signed [15:0]       third_value;
        logic signed [15:0]       fourth_value;
        logic [15:0]              heading;
        logic [COUNT_OUT_W-1:0]   good_count;
        logic [COUNT_OUT_W-1:0]   bad_count;
        logic [COUNT_OUT_W-1:0]   resync_count;
        logic [COUNT_OUT_W-1:0]   byte_count;
        logic                     online;
    } t_result;

endpackage

`default_nettype wire

>>> sv/imu_uart_frame_parser_core.sv
// IMU serial frame parser. Takes one received byte per transfer and returns one result for
// every completed 11-byte frame (header 0x55, type, eight payload bytes, checksum) and for
// every bad type byte after a header; other bytes give no result. A byte passes through an
// input register and then through the parser into the result register. One byte is taken in
// every cycle as long as the result register is empty or its result is being taken in the
// same cycle; the parser consumes a byte only when the result register can accept its
// outcome.
// Uses imufp_pkg, imufp_in_stage, imufp_parser and imufp_out_stage.
`default_nettype none

module imu_uart_frame_parser_core import imufp_pkg::*; #(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_event_res,
    output logic [7:0]              o_frame_type,
    output logic signed [15:0]      o_first_value,
    output logic signed [15:0]      o_second_value,
    output logic signed [15:0]      o_third_value,
    output logic signed [15:0]      o_fourth_value,
    output logic [15:0]             o_heading,
    output logic [COUNT_OUT_W-1:0]  o_good_count,
    output logic [COUNT_OUT_W-1:0]  o_bad_count,
    output logic [COUNT_OUT_W-1:0]  o_resync_count,
    output logic [COUNT_OUT_W-1:0]  o_byte_count,
    output logic                    o_online
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       parse_fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // The held byte is parsed when the result register is free or being drained.
    assign parse_fire = held_valid && (!o_out_valid || i_out_ready);

    imufp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_rx_byte),
        .i_take  (parse_fire),
        .o_valid (held_valid),
        .o_byte  (held_byte)
    );

    imufp_parser #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (parse_fire),
        .i_byte      (held_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    imufp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (parse_fire && res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_event_res    = out_res.event_res;
    assign o_frame_type   = out_res.frame_type;
    assign o_first_value  = out_res.first_value;
    assign o_second_value = out_res.second_value;
    assign o_third_value  = out_res.third_value;
    assign o_fourth_value = out_res.fourth_value;
    assign o_heading      = out_res.heading;
    assign o_good_count   = out_res.good_count;
    assign o_bad_count    = out_res.bad_count;
    assign o_resync_count = out_res.resync_count;
    assign o_byte_count   = out_res.byte_count;
    assign o_online       = out_res.online;

endmodule

`default_nettype wire

>>> sv/imufp_in_stage.sv
// Input register of the IMU frame parser: holds one received byte until the
// parser consumes it. Depends on nothing beyond the clock and reset.
`default_nettype none

module imufp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // A new byte may enter when the register is empty or is being drained.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

>>> sv/imufp_parser.sv
// Frame parser of the IMU serial stream: header hunt, type check, payload store,
// checksum, decode and statistics counters. Uses imufp_pkg.
`default_nettype none

module imufp_parser import imufp_pkg::*; #(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    t_state                    r_state, n_state;
    logic [7:0]                r_csum, n_csum;
    logic [PAY_IDX_W-1:0]      r_idx, n_idx;
    logic [7:0]                r_type, n_type;
    logic [7:0]                r_payload [PAY_BYTES];
    logic [COUNTER_WIDTH-1:0]  r_good, n_good;
    logic [COUNTER_WIDTH-1:0]  r_bad, n_bad;
    logic [COUNTER_WIDTH-1:0]  r_resync, n_resync;
    logic [COUNTER_WIDTH-1:0]  r_bytes, n_bytes;
    logic                      r_angle, n_angle;
    logic                      pay_we;

    always_comb begin
        n_state     = r_state;
        n_csum      = r_csum;
        n_idx       = r_idx;
        n_type      = r_type;
        n_good      = r_good;
        n_bad       = r_bad;
        n_resync    = r_resync;
        n_bytes     = r_bytes;
        n_angle     = r_angle;
        pay_we      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            n_bytes = r_bytes + CNT_ONE;
            case (r_state)
                ST_HUNT: begin
                    if (i_byte == HDR_BYTE) begin
                        n_csum  = i_byte;
                        n_state = ST_TYPE;
                    end
                end
                ST_TYPE: begin
                    if (i_byte inside {[TYPE_LO:TYPE_HI]}) begin
                        n_type  = i_byte;
                        n_csum  = r_csum + i_byte;
                        n_idx   = '0;
                        n_state = ST_PAYLOAD;
                    end else begin
                        n_state           = ST_HUNT;
                        n_csum            = '0;
                        n_resync          = r_resync + CNT_ONE;
                        o_res_valid       = 1'b1;
                        o_res.event_res   = EV_RESYNC;
                        o_res.frame_type  = i_byte;
                    end
                end
                ST_PAYLOAD: begin
                    pay_we = 1'b1;
                    n_csum = r_csum + i_byte;
                    n_idx  = r_idx + PAY_IDX_W'(1);
                    if (r_idx == PAY_LAST) begin
                        n_state = ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    n_state          = ST_HUNT;
                    n_csum           = '0;
                    o_res_valid      = 1'b1;
                    o_res.frame_type = r_type;
                    if (i_byte != r_csum) begin
                        n_bad           = r_bad + CNT_ONE;
                        o_res.event_res = EV_BADSUM;
                    end else begin
                        n_good             = r_good + CNT_ONE;
                        o_res.first_value  = {r_payload[1], r_payload[0]};
                        o_res.second_value = {r_payload[3], r_payload[2]};
                        o_res.third_value  = {r_payload[5], r_payload[4]};
                        o_res.fourth_value = {r_payload[7], r_payload[6]};
                        case (r_type)
                            TYPE_ACCEL: o_res.event_res = EV_ACCEL;
                            TYPE_GYRO:  o_res.event_res = EV_GYRO;
                            TYPE_ANGLE: begin
                                // Raw yaw read as unsigned is the 0..360 degree heading.
                                o_res.event_res = EV_ANGLE;
                                o_res.heading   = {r_payload[5], r_payload[4]};
                                n_angle         = 1'b1;
                            end
                            default:    o_res.event_res = EV_OTHER;
                        endcase
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                    n_csum  = '0;
                end
            endcase
        end

        o_res.good_count   = COUNT_OUT_W'(n_good);
        o_res.bad_count    = COUNT_OUT_W'(n_bad);
        o_res.resync_count = COUNT_OUT_W'(n_resync);
        o_res.byte_count   = COUNT_OUT_W'(n_bytes);
        o_res.online       = n_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_csum   <= '0;
            r_idx    <= '0;
            r_good   <= '0;
            r_bad    <= '0;
            r_resync <= '0;
            r_bytes  <= '0;
            r_angle  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_csum   <= n_csum;
            r_idx    <= n_idx;
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_resync <= n_resync;
            r_bytes  <= n_bytes;
            r_angle  <= n_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        if (pay_we) begin
            r_payload[r_idx] <= i_byte;
        end
    end

`ifndef SYNTHESIS
    // The running sum is only live inside a frame.
    a_csum_clear_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HUNT) |-> (r_csum == '0))
        else $error("checksum accumulator not clear while hunting");

    a_check_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_state == ST_CHECK) |=> (r_state == ST_HUNT))
        else $error("parser did not return to hunting after the checksum byte");

    a_byte_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_bytes == $past(r_bytes) + CNT_ONE))
        else $error("byte counter did not advance on a consumed byte");

    a_online_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_angle))
        else $error("angle-seen flag cleared outside reset");
`endif

endmodule

`default_nettype wire

>>> sv/imufp_top_dummy_placeholder.sv
// Result register stage of the IMU frame parser: holds one finished result
// until it is taken. Uses imufp_pkg.
`default_nettype none

module imufp_out_stage import imufp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> sim/imu_uart_frame_parser_tb.sv
// Self-checking testbench for imu_uart_frame_parser_core: sends byte streams of frames,
// broken frames and noise, predicts every result and compares each one field by field.
// Depends on imufp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module testbench import imufp_pkg::*; ();

    localparam int unsigned RANDOM_BYTES = 700;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_REPORTS  = 10;

    // Holds the parser's state as the bytes arrive and queues the results it should give.
    class frame_checker;
        localparam logic [3:0] POS_HUNT = 4'd0;
        localparam logic [3:0] POS_TYPE = 4'd1;
        localparam logic [3:0] POS_SUM  = 4'd10;

        t_result     expected_frames[$];
        logic [3:0]  pos;
        logic [7:0]  sum_acc;
        logic [7:0]  frame_kind;
        logic [7:0]  payload[8];
        logic [31:0] good_n, bad_n, resync_n, byte_n;
        logic        angle_seen;
        int unsigned errors;
        int unsigned checked;
        int unsigned event_hits[6];

        function new();
            pos        = POS_HUNT;
            sum_acc    = '0;
            frame_kind = '0;
            foreach (payload[i]) payload[i] = '0;
            good_n     = '0;
            bad_n      = '0;
            resync_n   = '0;
            byte_n     = '0;
            angle_seen = 1'b0;
            errors     = 0;
            checked    = 0;
            foreach (event_hits[i]) event_hits[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        function void push_result(t_result r);
            r.good_count   = good_n;
            r.bad_count    = bad_n;
            r.resync_count = resync_n;
            r.byte_count   = byte_n;
            r.online       = angle_seen;
            expected_frames.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            t_result r;
            r = '0;
            byte_n = byte_n + 32'd1;
            if (pos == POS_HUNT) begin
                if (b == HDR_BYTE) begin
                    sum_acc = b;
                    pos     = POS_TYPE;
                end
            end else if (pos == POS_TYPE) begin
                if (b >= TYPE_LO && b <= TYPE_HI) begin
                    frame_kind = b;
                    sum_acc    = sum_acc + b;
                    pos        = 4'd2;
                end else begin
                    pos          = POS_HUNT;
                    sum_acc      = '0;
                    resync_n     = resync_n + 32'd1;
                    r.event_res  = EV_RESYNC;
                    r.frame_type = b;
                    push_result(r);
                end
            end else if (pos < POS_SUM) begin
                payload[3'(pos - 4'd2)] = b;
                sum_acc = sum_acc + b;
                pos     = pos + 4'd1;
            end else begin
                pos          = POS_HUNT;
                r.frame_type = frame_kind;
                if (b != sum_acc) begin
                    bad_n       = bad_n + 32'd1;
                    r.event_res = EV_BADSUM;
                end else begin
                    good_n         = good_n + 32'd1;
                    r.first_value  = {payload[1], payload[0]};
                    r.second_value = {payload[3], payload[2]};
                    r.third_value  = {payload[5], payload[4]};
                    r.fourth_value = {payload[7], payload[6]};
                    case (frame_kind)
                        TYPE_ACCEL: r.event_res = EV_ACCEL;
                        TYPE_GYRO:  r.event_res = EV_GYRO;
                        TYPE_ANGLE: begin
                            r.event_res = EV_ANGLE;
                            r.heading   = r.third_value;
                            angle_seen  = 1'b1;
                        end
                        default:    r.event_res = EV_OTHER;
                    endcase
                end
                sum_acc = '0;
                push_result(r);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d: %s expected %h, got %h", checked, name, want, seen);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_frames.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: event %0d, type %h", got.event_res,
                             got.frame_type);
            end else begin
                want = expected_frames.pop_front();
                if (int'(want.event_res) < 6) event_hits[int'(want.event_res)]++;
                compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
                compare_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
                compare_field("first_value", 32'(want.first_value), 32'(got.first_value));
                compare_field("second_value", 32'(want.second_value), 32'(got.second_value));
                compare_field("third_value", 32'(want.third_value), 32'(got.third_value));
                compare_field("fourth_value", 32'(want.fourth_value), 32'(got.fourth_value));
                compare_field("heading", 32'(want.heading), 32'(got.heading));
                compare_field("good_count", want.good_count, got.good_count);
                compare_field("bad_count", want.bad_count, got.bad_count);
                compare_field("resync_count", want.resync_count, got.resync_count);
                compare_field("byte_count", want.byte_count, got.byte_count);
                compare_field("online", 32'(want.online), 32'(got.online));
                checked++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_event_res;
    logic [7:0]  o_frame_type;
    logic signed [15:0] o_first_value, o_second_value, o_third_value, o_fourth_value;
    logic [15:0] o_heading;
    logic [COUNT_OUT_W-1:0] o_good_count, o_bad_count, o_resync_count, o_byte_count;
    logic        o_online;

    frame_checker checker_q = new();
    bit           steady_phase    = 1'b0;
    int unsigned  holds_requested = 0;
    int unsigned  holds_done      = 0;
    int unsigned  sent_bytes      = 0;
    int unsigned  cycle_count     = 0;

    imu_uart_frame_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_frame_type   (o_frame_type),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_third_value  (o_third_value),
        .o_fourth_value (o_fourth_value),
        .o_heading      (o_heading),
        .o_good_count   (o_good_count),
        .o_bad_count    (o_bad_count),
        .o_resync_count (o_resync_count),
        .o_byte_count   (o_byte_count),
        .o_online       (o_online)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes a short one and now and then a long one; none in the steady phase.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_phase) return 0;
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'h7FFF;
                2:       return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) checker_q.take_byte(i_rx_byte);
            if (o_out_valid && i_out_ready) begin
                got.event_res    = t_event'(o_event_res);
                got.frame_type   = o_frame_type;
                got.first_value  = o_first_value;
                got.second_value = o_second_value;
                got.third_value  = o_third_value;
                got.fourth_value = o_fourth_value;
                got.heading      = o_heading;
                got.good_count   = o_good_count;
                got.bad_count    = o_bad_count;
                got.resync_count = o_resync_count;
                got.byte_count   = o_byte_count;
                got.online       = o_online;
                checker_q.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     checker_q.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the sender asks for one.
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holds_done < holds_requested) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left  = pick_gap();
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
    endtask

    // Sends header, type, payload and checksum; stops after keep payload bytes for a broken frame.
    task automatic send_frame(input logic [7:0] kind, input logic [63:0] data,
                              input bit spoil_sum, input int unsigned keep);
        logic [7:0] sum;
        sum = HDR_BYTE + kind;
        put_byte(HDR_BYTE);
        put_byte(kind);
        for (int i = 0; i < keep; i++) begin
            put_byte(data[8*i +: 8]);
            sum = sum + data[8*i +: 8];
        end
        if (keep == 8) begin
            if (spoil_sum) sum = sum ^ 8'($urandom_range(1, 255));
            put_byte(sum);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (checker_q.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(input int unsigned until_bytes);
        int unsigned pick;
        logic [7:0]  kind;
        logic [63:0] data;
        while (sent_bytes < until_bytes) begin
            pick = $urandom_range(0, 99);
            data = {pick_word(), pick_word(), pick_word(), pick_word()};
            if (pick < 65) begin
                if ($urandom_range(0, 99) < 60)
                    kind = 8'($urandom_range(TYPE_ACCEL, TYPE_ANGLE));
                else
                    kind = 8'($urandom_range(TYPE_LO, TYPE_HI));
                send_frame(kind, data, $urandom_range(0, 99) < 15, 8);
            end else if (pick < 75) begin
                do kind = 8'($urandom); while (kind >= TYPE_LO && kind <= TYPE_HI);
                put_byte(HDR_BYTE);
                put_byte(kind);
            end else if (pick < 85) begin
                kind = 8'($urandom_range(TYPE_LO, TYPE_HI));
                send_frame(kind, data, 1'b0, $urandom_range(0, 7));
            end else begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int unsigned directed_bytes;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Dropped bytes while hunting, two rejected type bytes, then an angle frame with
        // the most negative yaw and an accel frame with every extreme value.
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(HDR_BYTE);
        put_byte(TYPE_LO - 8'd1);
        put_byte(HDR_BYTE);
        put_byte(TYPE_HI + 8'd1);
        send_frame(TYPE_ANGLE, 64'hFFFF_8000_7FFF_8000, 1'b0, 8);
        send_frame(TYPE_ACCEL, 64'hFFFF_0000_8000_7FFF, 1'b0, 8);
        wait_drained();
        directed_bytes = sent_bytes;

        // Back-to-back bytes while the result side holds off, so the input must stall.
        steady_phase = 1'b1;
        holds_requested++;
        run_traffic(directed_bytes + 150);
        steady_phase = 1'b0;
        run_traffic(directed_bytes + 450);
        wait_drained();
        run_traffic(directed_bytes + RANDOM_BYTES);
        wait_drained();

        $display("sent %0d bytes in %0d cycles; checked %0d results", sent_bytes,
                 cycle_count, checker_q.checked);
        $display("accel %0d, gyro %0d, angle %0d, other %0d, bad checksum %0d, resync %0d",
                 checker_q.event_hits[EV_ACCEL], checker_q.event_hits[EV_GYRO],
                 checker_q.event_hits[EV_ANGLE], checker_q.event_hits[EV_OTHER],
                 checker_q.event_hits[EV_BADSUM], checker_q.event_hits[EV_RESYNC]);
        if (checker_q.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
